// ----- hw/rtl/eds_pkg.sv -----
// ----------------------------------------------------------------------------
// eds_pkg
// Shared constants, command and status types of the exact double sum core.
// ----------------------------------------------------------------------------
package eds_pkg;

   localparam int WORD_COUNT_DEF = 45;

   // request function codes
   localparam logic [1:0] FUNC_ADD     = 2'd0;
   localparam logic [1:0] FUNC_ADD_FIN = 2'd1;
   localparam logic [1:0] FUNC_FIN     = 2'd2;
   localparam logic [1:0] FUNC_NONE    = 2'd3;

   // binary64 fields and constants
   localparam logic [10:0] EXP_ALL    = 11'h7FF;
   localparam logic [63:0] QNAN_BITS  = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] PINF_BITS  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
   localparam int          SUBN_LIMIT = 52;   // top bit below this: subnormal
   localparam int          FIELD_OFS  = 51;   // top bit position minus biased exponent
   localparam int          FIELD_INF  = 2047;

   // datapath operations
   localparam logic [4:0] OP_NONE   = 5'd0;
   localparam logic [4:0] OP_LOAD   = 5'd1;
   localparam logic [4:0] OP_CLASS  = 5'd2;
   localparam logic [4:0] OP_ADD_RD = 5'd3;
   localparam logic [4:0] OP_ADD_WR = 5'd4;
   localparam logic [4:0] OP_CMP_RD = 5'd5;
   localparam logic [4:0] OP_CMP_EV = 5'd6;
   localparam logic [4:0] OP_DECIDE = 5'd7;
   localparam logic [4:0] OP_SUB_RD = 5'd8;
   localparam logic [4:0] OP_SUB_EV = 5'd9;
   localparam logic [4:0] OP_TOP_RD = 5'd10;
   localparam logic [4:0] OP_TOP_LD = 5'd11;
   localparam logic [4:0] OP_BEL_RD = 5'd12;
   localparam logic [4:0] OP_BEL_LD = 5'd13;
   localparam logic [4:0] OP_NORM   = 5'd14;
   localparam logic [4:0] OP_RND    = 5'd15;
   localparam logic [4:0] OP_CLEAR  = 5'd16;

   typedef struct packed {
      logic [4:0] op;
      logic [2:0] step;
   } cmd_type;

   typedef struct packed {
      logic       finite_nz;
      logic       finish;
      logic       more;
      logic       early;
      logic       found;
      logic       top_zero;
      logic [4:0] add_idx;
   } stat_type;

endpackage

// ----- hw/rtl/exact_double_sum_core.sv -----
// ----------------------------------------------------------------------------
// exact_double_sum_core
// Exact sum of a stream of binary64 values in two long fixed-point
// accumulators, correctly rounded to nearest-even on the finishing item.
//
//   channel   ports                               handshake
//   request   req_func, req_value_bits            start & !busy
//   result    rsp_sum_bits                        rsp_valid, one cycle
//
// An add item touches one or two accumulator words, more while a carry
// ripples, with one RAM read and one write per word.
// A finishing item adds the compare sweep, the decision and the subtract
// sweep, then normalize, round and output; special and all-zero sums skip
// the subtract sweep, normalize and round.
// Reset is synchronous; all words read as zero after reset via valid bits.
// The result strobe cannot be stalled; busy drops the cycle after it.
// ----------------------------------------------------------------------------
module exact_double_sum_core #(
   parameter int WORD_COUNT = eds_pkg::WORD_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_value_bits,
   output logic        rsp_valid,
   output logic [63:0] rsp_sum_bits
);

   eds_pkg::cmd_type              cmd;
   eds_pkg::stat_type             stat;
   logic [$clog2(WORD_COUNT)-1:0] ctr;

   eds_ctrl #(.WORD_COUNT(WORD_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .stat      (stat),
      .cmd       (cmd),
      .ctr       (ctr),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   eds_dpath #(.WORD_COUNT(WORD_COUNT)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .ctr            (ctr),
      .req_func       (req_func),
      .req_value_bits (req_value_bits),
      .stat           (stat),
      .result         (rsp_sum_bits)
   );

`ifndef SYNTHESIS
   // a result only comes out of a busy block
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");

   // the block is ready again right after a result
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid)) else $error("no return to idle after result");

   // an accepted item with a real function starts work
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func != eds_pkg::FUNC_NONE)) |=> busy)
      else $error("accepted item did not start");

   // an ignored item leaves the block idle
   a_none_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == eds_pkg::FUNC_NONE)) |=> !busy)
      else $error("ignored item started work");
`endif

endmodule

// ----- hw/rtl/eds_ram.sv -----
// ----------------------------------------------------------------------------
// eds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eds_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 45
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/eds_ctrl.sv -----
// ----------------------------------------------------------------------------
// eds_ctrl
// Sequencer of the exact double sum core: add ripple, compare, subtract,
// normalize and round passes over the accumulator words.
// ----------------------------------------------------------------------------
module eds_ctrl #(
   parameter int WORD_COUNT = eds_pkg::WORD_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [1:0]                    req_func,
   input  eds_pkg::stat_type             stat,
   output eds_pkg::cmd_type              cmd,
   output logic [$clog2(WORD_COUNT)-1:0] ctr,
   output logic                          busy,
   output logic                          rsp_valid
);

   localparam int IW = $clog2(WORD_COUNT);
   localparam logic [IW-1:0] LAST = IW'(WORD_COUNT - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLASS  = 4'd1;
   localparam logic [3:0] S_ADD_RD = 4'd2;
   localparam logic [3:0] S_ADD_WR = 4'd3;
   localparam logic [3:0] S_CMP_RD = 4'd4;
   localparam logic [3:0] S_CMP_EV = 4'd5;
   localparam logic [3:0] S_DECIDE = 4'd6;
   localparam logic [3:0] S_SUB_RD = 4'd7;
   localparam logic [3:0] S_SUB_EV = 4'd8;
   localparam logic [3:0] S_TOP_RD = 4'd9;
   localparam logic [3:0] S_TOP_LD = 4'd10;
   localparam logic [3:0] S_BEL_RD = 4'd11;
   localparam logic [3:0] S_BEL_LD = 4'd12;
   localparam logic [3:0] S_NORM   = 4'd13;
   localparam logic [3:0] S_RND    = 4'd14;
   localparam logic [3:0] S_OUT    = 4'd15;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] ctr_ff, ctr_in;
   logic [2:0]    step_ff, step_in;
   logic [4:0]    op;

   // next state and word counter
   always_comb begin
      state_in = state_ff;
      ctr_in   = ctr_ff;
      step_in  = step_ff;
      op       = eds_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start && (req_func != eds_pkg::FUNC_NONE)) begin
               op       = eds_pkg::OP_LOAD;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            op = eds_pkg::OP_CLASS;
            if (stat.finite_nz) begin
               ctr_in   = IW'(stat.add_idx);
               state_in = S_ADD_RD;
            end else if (stat.finish) begin
               ctr_in   = LAST;
               state_in = S_CMP_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADD_RD: begin
            op       = eds_pkg::OP_ADD_RD;
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            op = eds_pkg::OP_ADD_WR;
            if (stat.more && (ctr_ff != LAST)) begin
               ctr_in   = ctr_ff + 1'b1;
               state_in = S_ADD_RD;
            end else if (stat.finish) begin
               ctr_in   = LAST;
               state_in = S_CMP_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CMP_RD: begin
            op       = eds_pkg::OP_CMP_RD;
            state_in = S_CMP_EV;
         end
         S_CMP_EV: begin
            op = eds_pkg::OP_CMP_EV;
            if (ctr_ff == '0) begin
               state_in = S_DECIDE;
            end else begin
               ctr_in   = ctr_ff - 1'b1;
               state_in = S_CMP_RD;
            end
         end
         S_DECIDE: begin
            op = eds_pkg::OP_DECIDE;
            if (stat.early) begin
               state_in = S_OUT;
            end else begin
               ctr_in   = '0;
               state_in = S_SUB_RD;
            end
         end
         S_SUB_RD: begin
            op       = eds_pkg::OP_SUB_RD;
            state_in = S_SUB_EV;
         end
         S_SUB_EV: begin
            op = eds_pkg::OP_SUB_EV;
            if (ctr_ff == LAST) begin
               state_in = stat.found ? S_TOP_RD : S_OUT;
            end else begin
               ctr_in   = ctr_ff + 1'b1;
               state_in = S_SUB_RD;
            end
         end
         S_TOP_RD: begin
            op       = eds_pkg::OP_TOP_RD;
            state_in = S_TOP_LD;
         end
         S_TOP_LD: begin
            op       = eds_pkg::OP_TOP_LD;
            step_in  = '0;
            state_in = stat.top_zero ? S_NORM : S_BEL_RD;
         end
         S_BEL_RD: begin
            op       = eds_pkg::OP_BEL_RD;
            state_in = S_BEL_LD;
         end
         S_BEL_LD: begin
            op       = eds_pkg::OP_BEL_LD;
            step_in  = '0;
            state_in = S_NORM;
         end
         S_NORM: begin
            op = eds_pkg::OP_NORM;
            if (step_ff == 3'd5) begin
               state_in = S_RND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_RND: begin
            op       = eds_pkg::OP_RND;
            state_in = S_OUT;
         end
         S_OUT: begin
            op       = eds_pkg::OP_CLEAR;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ctr_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
         step_ff  <= step_in;
      end
   end

   assign cmd.op    = op;
   assign cmd.step  = step_ff;
   assign ctr       = ctr_ff;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

// ----- hw/rtl/eds_dpath.sv -----
// ----------------------------------------------------------------------------
// eds_dpath
// Datapath of the exact double sum core: positive and negative accumulator
// RAMs, special-value flags, word adder, comparator, subtractor, normalizer
// and rounder.
// ----------------------------------------------------------------------------
module eds_dpath #(
   parameter int WORD_COUNT = eds_pkg::WORD_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  eds_pkg::cmd_type              cmd,
   input  logic [$clog2(WORD_COUNT)-1:0] ctr,
   input  logic [1:0]                    req_func,
   input  logic [63:0]                   req_value_bits,
   output eds_pkg::stat_type             stat,
   output logic [63:0]                   result
);

   localparam int IW = $clog2(WORD_COUNT);
   localparam int HW = IW + 6;

   // latched item
   logic [1:0]  func_ff;
   logic [63:0] value_ff;

   // flags
   logic pinf_ff, ninf_ff, nan_ff, pzero_ff, only0_ff;

   // add ripple
   logic [63:0] lo_ff, hi_ff;
   logic        carry_ff, sel_ff;

   // compare
   logic decided_ff, neg_ff, any_ff;

   // subtract
   logic          borrow_ff, found_ff, or1_ff, or2_ff, sticky_low_ff;
   logic [IW-1:0] top_ff;

   // normalize and round
   logic [63:0]  wtop_ff;
   logic [127:0] norm_ff;
   logic [5:0]   shift_ff;
   logic [63:0]  result_ff;

   // storage
   logic [WORD_COUNT-1:0] pos_valid_ff, neg_valid_ff;
   logic                  pos_rv_ff, neg_rv_ff;
   logic [63:0]           pos_rd, neg_rd, word_p, word_n;
   logic                  pos_we, neg_we;
   logic [63:0]           wr_word;
   logic [IW-1:0]         rd_addr;

   // item classification
   logic [10:0]  v_exp;
   logic [51:0]  v_frac;
   logic         v_neg, has_val, is_spec, is_zero;
   logic [63:0]  mag;
   logic [10:0]  bitpos;
   logic [127:0] shifted;

   // arithmetic
   logic [64:0]  add_sum, sub_diff;
   logic [63:0]  big, small_w;
   logic [HW-1:0] h;
   logic [52:0]  m;
   logic         rbit, sticky, inc;
   logic [53:0]  mr;
   logic [HW:0]  field;
   logic [63:0]  sign_w, special_res;

   assign v_exp   = value_ff[62:52];
   assign v_frac  = value_ff[51:0];
   assign v_neg   = value_ff[63];
   assign has_val = (func_ff == eds_pkg::FUNC_ADD) || (func_ff == eds_pkg::FUNC_ADD_FIN);
   assign is_spec = (v_exp == eds_pkg::EXP_ALL);
   assign is_zero = (v_exp == '0) && (v_frac == '0);
   assign mag     = {11'b0, (v_exp != '0), v_frac};
   assign bitpos  = (v_exp == '0) ? 11'd0 : (v_exp - 11'd1);
   assign shifted = {64'b0, mag} << bitpos[5:0];

   // read address: sweep counter, or the top word and the one below it
   always_comb begin
      case (cmd.op)
         eds_pkg::OP_TOP_RD: rd_addr = top_ff;
         eds_pkg::OP_BEL_RD: rd_addr = top_ff - 1'b1;
         default:            rd_addr = ctr;
      endcase
   end

   // mask words never written since the last clear
   assign word_p = pos_rv_ff ? pos_rd : '0;
   assign word_n = neg_rv_ff ? neg_rd : '0;

   assign add_sum  = {1'b0, (sel_ff ? word_n : word_p)} + {1'b0, lo_ff} + {64'b0, carry_ff};
   assign big      = neg_ff ? word_n : word_p;
   assign small_w  = neg_ff ? word_p : word_n;
   assign sub_diff = {1'b0, big} - {1'b0, small_w} - {64'b0, borrow_ff};

   assign pos_we  = ((cmd.op == eds_pkg::OP_ADD_WR) && !sel_ff) ||
                    (cmd.op == eds_pkg::OP_SUB_EV);
   assign neg_we  = (cmd.op == eds_pkg::OP_ADD_WR) && sel_ff;
   assign wr_word = (cmd.op == eds_pkg::OP_SUB_EV) ? sub_diff[63:0] : add_sum[63:0];

   eds_ram #(.WIDTH(64), .DEPTH(WORD_COUNT)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (ctr),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (pos_rd)
   );

   eds_ram #(.WIDTH(64), .DEPTH(WORD_COUNT)) u_neg_ram (
      .clock   (clock),
      .wr_en   (neg_we),
      .wr_addr (ctr),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (neg_rd)
   );

   // rounding of the normalized difference
   assign sign_w = neg_ff ? eds_pkg::SIGN_BIT : '0;
   assign h      = {top_ff, ~shift_ff};
   assign m      = norm_ff[127:75];
   assign rbit   = norm_ff[74];
   assign sticky = (norm_ff[73:0] != '0) || sticky_low_ff;
   assign inc    = rbit && (sticky || m[0]);
   assign mr     = {1'b0, m} + {53'b0, inc};
   assign field  = {1'b0, h} - (HW+1)'(eds_pkg::FIELD_OFS) + {{HW{1'b0}}, mr[53]};

   // special and all-zero results
   always_comb begin
      if (nan_ff || (pinf_ff && ninf_ff)) begin
         special_res = eds_pkg::QNAN_BITS;
      end else if (pinf_ff) begin
         special_res = eds_pkg::PINF_BITS;
      end else if (ninf_ff) begin
         special_res = eds_pkg::SIGN_BIT | eds_pkg::PINF_BITS;
      end else if (only0_ff && !pzero_ff) begin
         special_res = eds_pkg::SIGN_BIT;
      end else begin
         special_res = '0;
      end
   end

   // control-state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pinf_ff      <= 1'b0;
         ninf_ff      <= 1'b0;
         nan_ff       <= 1'b0;
         pzero_ff     <= 1'b0;
         only0_ff     <= 1'b1;
         pos_valid_ff <= '0;
         neg_valid_ff <= '0;
      end else begin
         case (cmd.op)
            eds_pkg::OP_CLASS: begin
               if (has_val) begin
                  if (is_spec) begin
                     only0_ff <= 1'b0;
                     if (v_frac != '0) begin
                        nan_ff <= 1'b1;
                     end else if (v_neg) begin
                        ninf_ff <= 1'b1;
                     end else begin
                        pinf_ff <= 1'b1;
                     end
                  end else if (is_zero) begin
                     if (!v_neg) begin
                        pzero_ff <= 1'b1;
                     end
                  end else begin
                     only0_ff <= 1'b0;
                  end
               end
            end
            eds_pkg::OP_ADD_WR: begin
               if (sel_ff) begin
                  neg_valid_ff[ctr] <= 1'b1;
               end else begin
                  pos_valid_ff[ctr] <= 1'b1;
               end
            end
            eds_pkg::OP_SUB_EV: begin
               pos_valid_ff[ctr] <= 1'b1;
            end
            eds_pkg::OP_CLEAR: begin
               pinf_ff      <= 1'b0;
               ninf_ff      <= 1'b0;
               nan_ff       <= 1'b0;
               pzero_ff     <= 1'b0;
               only0_ff     <= 1'b1;
               pos_valid_ff <= '0;
               neg_valid_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_rv_ff <= pos_valid_ff[rd_addr];
      neg_rv_ff <= neg_valid_ff[rd_addr];
      case (cmd.op)
         eds_pkg::OP_LOAD: begin
            func_ff  <= req_func;
            value_ff <= req_value_bits;
         end
         eds_pkg::OP_CLASS: begin
            lo_ff      <= shifted[63:0];
            hi_ff      <= shifted[127:64];
            carry_ff   <= 1'b0;
            sel_ff     <= v_neg;
            decided_ff <= 1'b0;
            neg_ff     <= 1'b0;
            any_ff     <= 1'b0;
         end
         eds_pkg::OP_ADD_WR: begin
            lo_ff    <= hi_ff;
            hi_ff    <= '0;
            carry_ff <= add_sum[64];
         end
         eds_pkg::OP_CMP_EV: begin
            if ((word_p != '0) || (word_n != '0)) begin
               any_ff <= 1'b1;
            end
            if (!decided_ff) begin
               if (word_p > word_n) begin
                  decided_ff <= 1'b1;
                  neg_ff     <= 1'b0;
               end else if (word_p < word_n) begin
                  decided_ff <= 1'b1;
                  neg_ff     <= 1'b1;
               end
            end
         end
         eds_pkg::OP_DECIDE: begin
            borrow_ff     <= 1'b0;
            found_ff      <= 1'b0;
            or1_ff        <= 1'b0;
            or2_ff        <= 1'b0;
            sticky_low_ff <= 1'b0;
            top_ff        <= '0;
            result_ff     <= special_res;
         end
         eds_pkg::OP_SUB_EV: begin
            borrow_ff <= sub_diff[64];
            result_ff <= '0;
            if (sub_diff[63:0] != '0) begin
               top_ff        <= ctr;
               found_ff      <= 1'b1;
               sticky_low_ff <= or2_ff;
            end
            or2_ff <= or1_ff;
            or1_ff <= or1_ff || (sub_diff[63:0] != '0);
         end
         eds_pkg::OP_TOP_LD: begin
            wtop_ff  <= word_p;
            norm_ff  <= {word_p, 64'b0};
            shift_ff <= '0;
         end
         eds_pkg::OP_BEL_LD: begin
            norm_ff[63:0] <= word_p;
         end
         eds_pkg::OP_NORM: begin
            // one binary step of the leading-one search per cycle
            case (cmd.step)
               3'd0: if (norm_ff[127:96] == '0) begin
                  norm_ff     <= norm_ff << 32;
                  shift_ff[5] <= 1'b1;
               end
               3'd1: if (norm_ff[127:112] == '0) begin
                  norm_ff     <= norm_ff << 16;
                  shift_ff[4] <= 1'b1;
               end
               3'd2: if (norm_ff[127:120] == '0) begin
                  norm_ff     <= norm_ff << 8;
                  shift_ff[3] <= 1'b1;
               end
               3'd3: if (norm_ff[127:124] == '0) begin
                  norm_ff     <= norm_ff << 4;
                  shift_ff[2] <= 1'b1;
               end
               3'd4: if (norm_ff[127:126] == '0) begin
                  norm_ff     <= norm_ff << 2;
                  shift_ff[1] <= 1'b1;
               end
               3'd5: if (!norm_ff[127]) begin
                  norm_ff     <= norm_ff << 1;
                  shift_ff[0] <= 1'b1;
               end
               default: begin
               end
            endcase
         end
         eds_pkg::OP_RND: begin
            if (h < HW'(eds_pkg::SUBN_LIMIT)) begin
               result_ff <= sign_w | wtop_ff;
            end else if (field >= (HW+1)'(eds_pkg::FIELD_INF)) begin
               result_ff <= sign_w | eds_pkg::PINF_BITS;
            end else begin
               result_ff <= sign_w |
                            {1'b0, field[10:0], (mr[53] ? 52'b0 : mr[51:0])};
            end
         end
         default: begin
         end
      endcase
   end

   assign stat.finite_nz = has_val && !is_spec && !is_zero;
   assign stat.finish    = (func_ff != eds_pkg::FUNC_ADD);
   assign stat.more      = (hi_ff != '0) || add_sum[64];
   assign stat.early     = nan_ff || pinf_ff || ninf_ff || !any_ff;
   assign stat.found     = found_ff || (sub_diff[63:0] != '0);
   assign stat.top_zero  = (top_ff == '0);
   assign stat.add_idx   = bitpos[10:6];
   assign result         = result_ff;

endmodule
